@@ hw/rtl/dstep_pkg.sv @@
package dstep_pkg;

  // Door travel limits in half steps
  localparam logic [15:0] FULL_OPEN_STEPS = 16'd1024;
  localparam logic [15:0] PARTIAL_STEPS   = 16'd512;

  // Forced close window and test mode periods
  localparam logic [6:0]  WINDOW_TICKS      = 7'd70;
  localparam logic [15:0] TEST_PERIOD_TICKS = 16'd600;
  localparam logic [7:0]  TEST_PERIOD_COUNT = 8'd5;

  // Configuration register map
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEST_MODE         = 2'd0,
    REG_LONG_PERIOD_TICKS = 2'd1,
    REG_LONG_PERIOD_COUNT = 2'd2,
    REG_SHORT_CLOSE_TICKS = 2'd3
  } cfg_reg_t;

  // Operation codes
  localparam logic OP_MOTOR = 1'b0;
  localparam logic OP_TIMER = 1'b1;

  // Input word as held in the input register
  typedef struct packed {
    logic operation;
    logic open_set;
    logic open_clear;
    logic arm_short_close;
    logic dispensing;
    logic jam_idle;
    logic close_hold;
  } in_word_t;

  // Timer settings
  typedef struct packed {
    logic        test_mode;
    logic [15:0] long_period_ticks;
    logic [7:0]  long_period_count;
    logic [15:0] short_close_ticks;
  } timer_cfg_t;

  // Control from the step logic to the timers
  typedef struct packed {
    logic tick;        // timer tick being processed this cycle
    logic arm;         // arm short timer this cycle
    logic dispensing;
  } timer_ctl_t;

  // Timer status for the word being processed
  typedef struct packed {
    logic force_full;
    logic force_partial;
    logic long_active;
    logic short_active;
  } timer_stat_t;

  // Half-step coil pattern, bit0 is coil1
  function automatic logic [3:0] phase_coils(input logic [2:0] phase);
    logic [3:0] c;
    case (phase)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h9;
      3'd2:    c = 4'h8;
      3'd3:    c = 4'hC;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'h6;
      3'd6:    c = 4'h2;
      3'd7:    c = 4'h3;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/dstep_in_if.sv @@
interface dstep_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic open_set;
  logic open_clear;
  logic arm_short_close;
  logic dispensing;
  logic jam_idle;
  logic close_hold;

  modport source (
    output valid, operation, open_set, open_clear, arm_short_close,
           dispensing, jam_idle, close_hold,
    input  ready
  );

  modport sink (
    input  valid, operation, open_set, open_clear, arm_short_close,
           dispensing, jam_idle, close_hold,
    output ready
  );
endinterface

@@ hw/rtl/dstep_out_if.sv @@
interface dstep_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic [15:0] position;
  logic        open_command;
  logic        long_close_active;
  logic        short_close_active;

  modport source (
    output valid, coils, position, open_command, long_close_active,
           short_close_active,
    input  ready
  );

  modport sink (
    input  valid, coils, position, open_command, long_close_active,
           short_close_active,
    output ready
  );
endinterface

@@ hw/rtl/door_stepper_with_forced_close_unit.sv @@
// Door stepper sequencer with periodic forced close. Each input word is either
// a motor step tick or a slow timer tick and yields exactly one result word
// carrying the coil pattern, door position, open latch and the two forced
// close window flags. The block takes one word per clock cycle unless the
// result register is full and dout.ready is low; a word is held in the input
// register and then loaded into the result register (one input register, one
// result register), and the single result register lets a new word enter
// while the previous result waits on ready. Configuration is written through
// cfg_we, cfg_index and cfg_data and takes effect for words processed afterwards.
module door_stepper_with_forced_close_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dstep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dstep_pkg::CFG_DATA_W-1:0]  cfg_data,
  dstep_in_if.sink                          din,
  dstep_out_if.source                       dout
);
  import dstep_pkg::*;

  // Configuration registers
  timer_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.test_mode         <= 1'b0;
      cfg.long_period_ticks <= 16'd36000;
      cfg.long_period_count <= 8'd24;
      cfg.short_close_ticks <= 16'd12000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEST_MODE:         cfg.test_mode         <= cfg_data[0];
        REG_LONG_PERIOD_TICKS: cfg.long_period_ticks <= cfg_data[15:0];
        REG_LONG_PERIOD_COUNT: cfg.long_period_count <= cfg_data[7:0];
        REG_SHORT_CLOSE_TICKS: cfg.short_close_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic     s1_valid;
  in_word_t s1_word;
  logic     out_valid;
  logic     out_load;
  logic     s1_load;

  assign out_load  = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || out_load;
  assign s1_load   = din.valid && din.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word.operation       <= din.operation;
      s1_word.open_set        <= din.open_set;
      s1_word.open_clear      <= din.open_clear;
      s1_word.arm_short_close <= din.arm_short_close;
      s1_word.dispensing      <= din.dispensing;
      s1_word.jam_idle        <= din.jam_idle;
      s1_word.close_hold      <= din.close_hold;
    end
  end

  // Timers
  timer_ctl_t  tctl;
  timer_stat_t tstat;

  assign tctl.tick       = out_load && (s1_word.operation == OP_TIMER);
  assign tctl.arm        = out_load && s1_word.arm_short_close;
  assign tctl.dispensing = s1_word.dispensing;

  dstep_timers u_timers (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (tctl),
    .stat (tstat)
  );

  // Door state
  logic [15:0] position, position_next;
  logic        open_latch, open_latch_next;
  logic        was_opening, was_opening_next;
  logic        latch_in;
  logic [15:0] close_base;
  logic [3:0]  coils_next;

  always_comb begin
    latch_in         = (open_latch | s1_word.open_set) & ~s1_word.open_clear;
    open_latch_next  = latch_in;
    was_opening_next = was_opening;
    position_next    = position;
    close_base       = was_opening ? FULL_OPEN_STEPS : position;
    if (s1_word.operation == OP_MOTOR) begin
      if (latch_in) begin
        // opening: climb to full, then release latch when unit is quiet
        was_opening_next = 1'b1;
        if (position < FULL_OPEN_STEPS) begin
          position_next = position + 16'd1;
        end else begin
          position_next = FULL_OPEN_STEPS;
          if (!s1_word.dispensing && s1_word.jam_idle) begin
            open_latch_next = 1'b0;
          end
        end
      end else begin
        // closing: restart from full after an open, step down unless held
        was_opening_next = 1'b0;
        if (close_base != 16'd0 && !s1_word.close_hold) begin
          position_next = close_base - 16'd1;
        end else begin
          position_next = close_base;
        end
      end
    end else begin
      // forced closes; a partial close from the short timer wins over a full close
      if (tstat.force_partial) begin
        position_next = PARTIAL_STEPS;
      end else if (tstat.force_full) begin
        position_next = FULL_OPEN_STEPS;
      end
    end

    if (position_next != 16'd0 && position_next != FULL_OPEN_STEPS) begin
      coils_next = phase_coils(position_next[2:0]);
    end else begin
      coils_next = 4'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      open_latch  <= 1'b0;
      was_opening <= 1'b0;
    end else if (out_load) begin
      position    <= position_next;
      open_latch  <= open_latch_next;
      was_opening <= was_opening_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dout.coils              <= coils_next;
      dout.position           <= position_next;
      dout.open_command       <= open_latch_next;
      dout.long_close_active  <= tstat.long_active;
      dout.short_close_active <= tstat.short_active;
    end
  end

  assign dout.valid = out_valid;

  // Checks
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid)
    else $error("input word dropped while stalled");

  a_full_close: assert property (@(posedge clk) disable iff (rst)
    tstat.force_full && !tstat.force_partial |=> position == FULL_OPEN_STEPS)
    else $error("forced full close did not move door to full open");

  a_long_window: assert property (@(posedge clk) disable iff (rst)
    tstat.force_full |-> tstat.long_active)
    else $error("long close window not active after firing");

  a_coils_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && dout.position == 16'd0 |-> dout.coils == 4'h0)
    else $error("coils driven with door closed");

endmodule

@@ hw/rtl/dstep_timers.sv @@
module dstep_timers (
  input  logic                   clk,
  input  logic                   rst,
  input  dstep_pkg::timer_cfg_t  cfg,
  input  dstep_pkg::timer_ctl_t  ctl,
  output dstep_pkg::timer_stat_t stat
);
  import dstep_pkg::*;

  logic [15:0] period_tick_count, period_tick_count_next;
  logic [7:0]  period_count, period_count_next;
  logic [6:0]  long_window, long_window_next;
  logic [15:0] short_tick_count, short_tick_count_next;
  logic        short_armed, short_armed_next;
  logic [6:0]  short_window, short_window_next;

  logic [15:0] ticks_sel;
  logic [7:0]  count_sel;
  logic [15:0] ptc_inc;
  logic [7:0]  pc_base, pc_step;
  logic        long_fire;
  logic        armed_now;
  logic [15:0] stc_inc;
  logic        short_fire;
  logic [6:0]  lw_loaded, sw_loaded;

  // Long timer: ticks per period, then periods per forced full close
  always_comb begin
    ticks_sel = cfg.test_mode ? TEST_PERIOD_TICKS : cfg.long_period_ticks;
    count_sel = cfg.test_mode ? TEST_PERIOD_COUNT : cfg.long_period_count;
    ptc_inc   = (ctl.dispensing ? 16'd0 : period_tick_count) + 16'd1;
    pc_base   = ctl.dispensing ? 8'd0 : period_count;
    pc_step   = (ptc_inc >= ticks_sel) ? pc_base + 8'd1 : pc_base;
    long_fire = (pc_step >= count_sel);
    lw_loaded = long_fire ? WINDOW_TICKS : long_window;

    period_tick_count_next = period_tick_count;
    period_count_next      = period_count;
    long_window_next       = long_window;
    if (ctl.tick) begin
      if (long_fire || ptc_inc >= ticks_sel) begin
        period_tick_count_next = 16'd0;
      end else begin
        period_tick_count_next = ptc_inc;
      end
      period_count_next = long_fire ? 8'd0 : pc_step;
      long_window_next  = (lw_loaded != 7'd0) ? lw_loaded - 7'd1 : lw_loaded;
    end
  end

  // Short timer: frozen while disarmed, fires a partial close once
  always_comb begin
    armed_now  = short_armed | ctl.arm;
    stc_inc    = (ctl.dispensing ? 16'd0 : short_tick_count) + 16'd1;
    short_fire = ctl.tick && armed_now && (stc_inc >= cfg.short_close_ticks);
    sw_loaded  = short_fire ? WINDOW_TICKS : short_window;

    short_tick_count_next = short_tick_count;
    short_window_next     = short_window;
    short_armed_next      = armed_now;
    if (ctl.tick && armed_now) begin
      short_tick_count_next = short_fire ? 16'd0 : stc_inc;
      short_window_next     = (sw_loaded != 7'd0) ? sw_loaded - 7'd1 : sw_loaded;
      if (short_fire) begin
        short_armed_next = 1'b0;
      end
    end
  end

  // Status for the current word
  always_comb begin
    stat.force_full    = ctl.tick && long_fire;
    stat.force_partial = short_fire;
    stat.long_active   = (long_window_next != 7'd0);
    stat.short_active  = (short_window_next != 7'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_tick_count <= '0;
      period_count      <= '0;
      long_window       <= '0;
      short_tick_count  <= '0;
      short_armed       <= 1'b0;
      short_window      <= '0;
    end else if (ctl.tick || ctl.arm) begin
      period_tick_count <= period_tick_count_next;
      period_count      <= period_count_next;
      long_window       <= long_window_next;
      short_tick_count  <= short_tick_count_next;
      short_armed       <= short_armed_next;
      short_window      <= short_window_next;
    end
  end

endmodule

@@ tb/sv/tb_door_stepper_with_forced_close_unit.sv @@
`timescale 1ns / 1ps

module tb_door_stepper_with_forced_close_unit;
  import dstep_pkg::*;

  // Half-step coil nibbles, phase 0 in the low nibble
  localparam logic [31:0] COIL_SEQ = 32'h3264_C891;

  typedef struct packed {
    logic [3:0]  coils;
    logic [15:0] position;
    logic        open_command;
    logic        long_close_active;
    logic        short_close_active;
  } door_status_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dstep_in_if  din ();
  dstep_out_if dout ();

  door_stepper_with_forced_close_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  // Predicted door and timer state
  timer_cfg_t  timer_shadow = '{1'b0, 16'd36000, 8'd24, 16'd12000};
  logic [15:0] pos_q        = '0;
  logic        latch_q      = 1'b0;
  logic        rising_q     = 1'b0;
  logic [15:0] per_ticks_q  = '0;
  logic [7:0]  per_cnt_q    = '0;
  logic [6:0]  full_win_q   = '0;
  logic [15:0] part_ticks_q = '0;
  logic        part_armed_q = 1'b0;
  logic [6:0]  part_win_q   = '0;

  door_status_t pending_status[$];
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb_door_stepper_with_forced_close_unit failed");
    $finish;
  end

  // Advance the predicted state by one word and return the status it yields
  function automatic door_status_t step_door(input in_word_t w);
    logic [15:0] lim_ticks;
    logic [7:0]  lim_count;
    door_status_t r;
    if (w.open_set) latch_q = 1'b1;
    if (w.open_clear) latch_q = 1'b0;
    if (w.arm_short_close) part_armed_q = 1'b1;
    if (w.operation == OP_MOTOR) begin
      if (latch_q) begin
        rising_q = 1'b1;
        if (pos_q < FULL_OPEN_STEPS) begin
          pos_q = pos_q + 16'd1;
        end else begin
          pos_q = FULL_OPEN_STEPS;
          if (!w.dispensing && w.jam_idle) latch_q = 1'b0;
        end
      end else begin
        // a door that was opening restarts its close from full open
        if (rising_q) begin
          pos_q    = FULL_OPEN_STEPS;
          rising_q = 1'b0;
        end
        if (pos_q != 16'd0 && !w.close_hold) pos_q = pos_q - 16'd1;
      end
    end else begin
      // long timer: ticks per period, periods per forced full close
      lim_ticks = timer_shadow.test_mode ? TEST_PERIOD_TICKS : timer_shadow.long_period_ticks;
      lim_count = timer_shadow.test_mode ? TEST_PERIOD_COUNT : timer_shadow.long_period_count;
      if (w.dispensing) begin
        per_ticks_q = '0;
        per_cnt_q   = '0;
      end
      per_ticks_q = per_ticks_q + 16'd1;
      if (per_ticks_q >= lim_ticks) begin
        per_ticks_q = '0;
        per_cnt_q   = per_cnt_q + 8'd1;
      end
      if (per_cnt_q >= lim_count) begin
        per_ticks_q = '0;
        per_cnt_q   = '0;
        full_win_q  = WINDOW_TICKS;
        pos_q       = FULL_OPEN_STEPS;
      end
      if (full_win_q != 7'd0) full_win_q = full_win_q - 7'd1;
      // short timer is frozen entirely while disarmed
      if (part_armed_q) begin
        if (w.dispensing) part_ticks_q = '0;
        part_ticks_q = part_ticks_q + 16'd1;
        if (part_ticks_q >= timer_shadow.short_close_ticks) begin
          part_ticks_q = '0;
          part_win_q   = WINDOW_TICKS;
          pos_q        = PARTIAL_STEPS;
          part_armed_q = 1'b0;
        end
        if (part_win_q != 7'd0) part_win_q = part_win_q - 7'd1;
      end
    end
    if (pos_q == 16'd0 || pos_q == FULL_OPEN_STEPS) r.coils = 4'h0;
    else r.coils = COIL_SEQ[pos_q[2:0]*4 +: 4];
    r.position           = pos_q;
    r.open_command       = latch_q;
    r.long_close_active  = (full_win_q != 7'd0);
    r.short_close_active = (part_win_q != 7'd0);
    return r;
  endfunction

  function automatic in_word_t door_word(input logic op, input logic set, input logic clr,
                                         input logic arm, input logic disp, input logic jam,
                                         input logic hold);
    in_word_t w;
    w.operation       = op;
    w.open_set        = set;
    w.open_clear      = clr;
    w.arm_short_close = arm;
    w.dispensing      = disp;
    w.jam_idle        = jam;
    w.close_hold      = hold;
    return w;
  endfunction

  // Mostly plausible traffic; one word in ten is plain noise
  function automatic in_word_t random_word();
    in_word_t w;
    if ($urandom_range(9) == 0) begin
      w = door_word(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
    end else begin
      w = door_word(1'($urandom_range(1)),
                    $urandom_range(99) < 12, $urandom_range(99) < 8,
                    $urandom_range(99) < 15, $urandom_range(99) < 15,
                    $urandom_range(99) < 85, $urandom_range(99) < 20);
    end
    return w;
  endfunction

  // Send one word; valid stays high on return so back-to-back words flow
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid           <= 1'b1;
    din.operation       <= w.operation;
    din.open_set        <= w.open_set;
    din.open_clear      <= w.open_clear;
    din.arm_short_close <= w.arm_short_close;
    din.dispensing      <= w.dispensing;
    din.jam_idle        <= w.jam_idle;
    din.close_hold      <= w.close_hold;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    pending_status.push_back(step_door(w));
  endtask

  task automatic wait_drained();
    din.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_TEST_MODE:         timer_shadow.test_mode         = val[0];
      REG_LONG_PERIOD_TICKS: timer_shadow.long_period_ticks = val;
      REG_LONG_PERIOD_COUNT: timer_shadow.long_period_count = val[7:0];
      REG_SHORT_CLOSE_TICKS: timer_shadow.short_close_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_timers(input logic tm, input logic [15:0] lpt, input logic [7:0] lpc,
                            input logic [15:0] sct);
    write_reg(REG_TEST_MODE, {15'd0, tm});
    write_reg(REG_LONG_PERIOD_TICKS, lpt);
    write_reg(REG_LONG_PERIOD_COUNT, {8'd0, lpc});
    write_reg(REG_SHORT_CLOSE_TICKS, sct);
    cfg_we <= 1'b0;
  endtask

  // Open latch, set/clear priority, stepping up and down, hold, full-open release
  task automatic test_latch_and_stepping();
    set_timers(1'b0, 16'd3, 8'd2, 16'd4);
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 1));
    send_word(door_word(OP_MOTOR, 1, 1, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 1, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 1, 0, 0, 1, 1));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 1, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    // at full open the latch only drops when not dispensing and jam idle
    send_word(door_word(OP_MOTOR, 0, 0, 0, 1, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 0, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
  endtask

  // Short timer armed and restarted, partial close, then a full close
  task automatic test_forced_close();
    send_word(door_word(OP_TIMER, 0, 0, 1, 0, 1, 0));
    send_word(door_word(OP_TIMER, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_TIMER, 0, 0, 0, 1, 1, 0));
    repeat (6) send_word(door_word(OP_TIMER, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 0, 0, 1, 0));
    send_word(door_word(OP_MOTOR, 0, 0, 1, 0, 1, 0));
  endtask

  // Zero limits fire the long timer on every tick and the armed short timer at once; test mode overrides the long timer
  task automatic test_zero_limits();
    wait_drained();
    set_timers(1'b0, 16'd0, 8'd0, 16'd0);
    send_word(door_word(OP_TIMER, 0, 0, 1, 0, 1, 0));
    send_word(door_word(OP_TIMER, 0, 0, 0, 0, 1, 0));
    wait_drained();
    set_timers(1'b1, 16'd0, 8'd0, 16'd2);
    send_word(door_word(OP_TIMER, 0, 0, 1, 0, 1, 0));
    send_word(door_word(OP_TIMER, 0, 0, 0, 0, 1, 0));
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_stall, input logic tm,
                                     input logic [15:0] lpt, input logic [7:0] lpc,
                                     input logic [15:0] sct, input int n);
    wait_drained();
    set_timers(tm, lpt, lpc, sct);
    sender_idle_pct = s_idle;
    recv_stall_pct  = r_stall;
    repeat (n) send_word(random_word());
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    dout.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin
    door_status_t got;
    door_status_t want;
    if (!rst && dout.valid && dout.ready) begin
      got = {dout.coils, dout.position, dout.open_command, dout.long_close_active,
             dout.short_close_active};
      if (pending_status.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected word: coils=%h pos=%0d open=%b long=%b short=%b",
                   got.coils, got.position, got.open_command, got.long_close_active,
                   got.short_close_active);
      end else begin
        want = pending_status.pop_front();
        if (got.coils !== want.coils || got.position !== want.position ||
            got.open_command !== want.open_command ||
            got.long_close_active !== want.long_close_active ||
            got.short_close_active !== want.short_close_active) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: exp coils=%h pos=%0d open=%b long=%b short=%b",
                      " | got coils=%h pos=%0d open=%b long=%b short=%b"},
                     want.coils, want.position, want.open_command,
                     want.long_close_active, want.short_close_active,
                     got.coils, got.position, got.open_command,
                     got.long_close_active, got.short_close_active);
        end
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_TEST_MODE;
    cfg_data            <= '0;
    din.valid           <= 1'b0;
    din.operation       <= OP_MOTOR;
    din.open_set        <= 1'b0;
    din.open_clear      <= 1'b0;
    din.arm_short_close <= 1'b0;
    din.dispensing      <= 1'b0;
    din.jam_idle        <= 1'b0;
    din.close_hold      <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_latch_and_stepping();
    test_forced_close();
    test_zero_limits();
    test_random_traffic(0, 0, 1'b0, 16'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                        16'($urandom_range(24, 1)), 100);
    test_random_traffic(71, 0, 1'b0, 16'd1, 8'd1, 16'd1, 100);
    test_random_traffic(0, 71, 1'b0, 16'hFFFF, 8'hFF, 16'hFFFF, 100);
    test_random_traffic(12, 12, 1'b1, 16'($urandom_range(65535, 1)),
                        8'($urandom_range(255, 1)), 16'($urandom_range(40, 1)), 100);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("tb_door_stepper_with_forced_close_unit passed");
    end else begin
      $display("tb_door_stepper_with_forced_close_unit failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dstep_pkg.sv
hw/rtl/dstep_in_if.sv
hw/rtl/dstep_out_if.sv
hw/rtl/dstep_timers.sv
hw/rtl/door_stepper_with_forced_close_unit.sv
tb/sv/tb_door_stepper_with_forced_close_unit.sv
